// ----- sv/lzw_pkg.sv -----
// ----------------------------------------------------------------------------
// LZW encoder package
// Field widths, table entry layout and stream constants shared by the block.
// ----------------------------------------------------------------------------
package lzw_pkg;

   localparam int CODE_W  = 12;
   localparam int SYM_W   = 7;
   localparam int KEY_W   = CODE_W + SYM_W;
   localparam int NEXT_W  = CODE_W + 1;
   localparam int EPOCH_W = 10;

   localparam int DICT_SIZE     = 4096;
   localparam int ALPHABET_SIZE = 128;

   // Epoch zero marks a cleared slot; live streams use 1 .. EPOCH_MAX.
   localparam logic [EPOCH_W-1:0] EPOCH_NONE  = '0;
   localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
   localparam logic [EPOCH_W-1:0] EPOCH_MAX   = '1;

   typedef struct packed {
      logic [EPOCH_W-1:0] epoch;
      logic [KEY_W-1:0]   key;
      logic [CODE_W-1:0]  code;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage

// ----- sv/lzw_if.sv -----
// ----------------------------------------------------------------------------
// LZW encoder channels
// Valid/ready channels for symbols, codes and the limit register write.
// ----------------------------------------------------------------------------
interface lzw_req_if;
   logic                       valid;
   logic                       ready;
   logic [lzw_pkg::SYM_W-1:0]  symbol;
   logic                       last_symbol;
   modport source (output valid, output symbol, output last_symbol, input ready);
   modport sink   (input valid, input symbol, input last_symbol, output ready);
endinterface

interface lzw_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [lzw_pkg::CODE_W-1:0] code;
   logic                       end_of_stream;
   modport source (output valid, output code, output end_of_stream, input ready);
   modport sink   (input valid, input code, input end_of_stream, output ready);
endinterface

interface lzw_csr_if;
   logic                       valid;
   logic                       ready;
   logic [lzw_pkg::CODE_W-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ----- sv/lzw_table.sv -----
// ----------------------------------------------------------------------------
// LZW hash table
// Single-port-write, single-port-read synchronous RAM, registered read data.
// ----------------------------------------------------------------------------
module lzw_table #(
   parameter int ADDR_W = 13
) (
   input  logic                          clock,
   input  logic                          rd_en,
   input  logic [ADDR_W-1:0]             rd_addr,
   output lzw_pkg::entry_type            rd_data,
   input  logic                          wr_en,
   input  logic [ADDR_W-1:0]             wr_addr,
   input  lzw_pkg::entry_type            wr_data
);

   lzw_pkg::entry_type mem [2**ADDR_W];
   lzw_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/lzw_encoder.sv -----
// ----------------------------------------------------------------------------
// LZW encoder
// Encodes a symbol stream into dictionary codes using a hashed pair table.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one symbol per word with last_symbol on the final one.
//   rsp returns codes; end_of_stream marks the flushed code of a stream.
//   csr writes code_limit (reset 4095); write it only while idle.
// Flow:
//   One symbol is in work at a time. A symbol that starts a stream needs no
//   table read; any other is hashed and looked up with linear probing in
//   the table RAM, one read per cycle, and a miss or a flush emits a code.
//   A code lands in the rsp output register, so the next symbol is taken
//   while that code still waits.
// Reset and clearing:
//   After reset the table is swept, one slot a cycle, over 2*2^clog2(DICT_SIZE)
//   slots (8192 slots) with req.ready low. Slots carry a stream epoch;
//   the same sweep runs again after every 1023rd stream ends.
// Stall:
//   While rsp is stalled, a pending code holds and req.ready stays low once
//   the next code has nowhere to go.
// ----------------------------------------------------------------------------
module lzw_encoder (
   input  logic      clock,
   input  logic      reset,
   lzw_req_if.sink   req,
   lzw_rsp_if.source rsp,
   lzw_csr_if.sink   csr
);

   localparam int DICT_SIZE     = lzw_pkg::DICT_SIZE;
   localparam int ALPHABET_SIZE = lzw_pkg::ALPHABET_SIZE;
   localparam int TAB_W = $clog2(DICT_SIZE) + 1;
   localparam int CODE_W = lzw_pkg::CODE_W;
   localparam int SYM_W  = lzw_pkg::SYM_W;
   localparam int KEY_W  = lzw_pkg::KEY_W;
   localparam int NEXT_W = lzw_pkg::NEXT_W;
   localparam int EPOCH_W = lzw_pkg::EPOCH_W;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_LOOK,
      S_MISS,
      S_FLUSH
   } state_type;

   state_type           state_ff, state_in;
   logic [CODE_W-1:0]   prefix_ff, prefix_in;
   logic                pvalid_ff, pvalid_in;
   logic [NEXT_W-1:0]   next_ff, next_in;
   logic [EPOCH_W-1:0]  epoch_ff, epoch_in;
   logic [TAB_W-1:0]    addr_ff, addr_in;
   logic [SYM_W-1:0]    sym_ff, sym_in;
   logic                last_ff, last_in;
   logic [CODE_W-1:0]   limit_ff;
   logic                out_valid_ff, out_valid_in;
   logic [CODE_W-1:0]   out_code_ff, out_code_in;
   logic                out_eos_ff, out_eos_in;

   logic                rd_en, wr_en;
   logic [TAB_W-1:0]    rd_addr;
   lzw_pkg::entry_type  rd_data, wr_data;

   logic                req_fire, out_free, can_learn;
   logic [SYM_W-1:0]    sym_mod;
   logic [KEY_W-1:0]    new_key, look_key;
   logic [TAB_W-1:0]    new_hash;

   assign req_fire = req.valid && req.ready;
   assign out_free = !out_valid_ff || rsp.ready;

   // fold the symbol into the alphabet
   assign sym_mod = SYM_W'(32'(req.symbol) % ALPHABET_SIZE);

   assign new_key  = {prefix_ff, sym_mod};
   assign look_key = {prefix_ff, sym_ff};
   assign new_hash = TAB_W'(new_key ^ (new_key >> TAB_W));
   assign can_learn = (next_ff <= {1'b0, limit_ff}) && (32'(next_ff) < DICT_SIZE);

   always_comb begin
      state_in     = state_ff;
      prefix_in    = prefix_ff;
      pvalid_in    = pvalid_ff;
      next_in      = next_ff;
      epoch_in     = epoch_ff;
      addr_in      = addr_ff;
      sym_in       = sym_ff;
      last_in      = last_ff;
      out_valid_in = out_valid_ff && !rsp.ready;
      out_code_in  = out_code_ff;
      out_eos_in   = out_eos_ff;
      rd_en        = 1'b0;
      rd_addr      = addr_ff;
      wr_en        = 1'b0;
      wr_data      = '0;
      case (state_ff)
         S_CLEAR: begin
            wr_en         = 1'b1;
            wr_data.epoch = lzw_pkg::EPOCH_NONE;
            addr_in       = addr_ff + TAB_W'(1);
            if (addr_ff == '1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_fire) begin
               sym_in  = sym_mod;
               last_in = req.last_symbol;
               if (!pvalid_ff) begin
                  prefix_in = CODE_W'(sym_mod);
                  pvalid_in = 1'b1;
                  if (req.last_symbol) begin
                     state_in = S_FLUSH;
                  end
               end else begin
                  rd_en    = 1'b1;
                  rd_addr  = new_hash;
                  addr_in  = new_hash;
                  state_in = S_LOOK;
               end
            end
         end
         S_LOOK: begin
            if (rd_data.epoch == epoch_ff) begin
               if (rd_data.key == look_key) begin
                  prefix_in = rd_data.code;
                  state_in  = last_ff ? S_FLUSH : S_IDLE;
               end else begin
                  // occupied by another pair: advance to the next slot
                  rd_en   = 1'b1;
                  rd_addr = addr_ff + TAB_W'(1);
                  addr_in = addr_ff + TAB_W'(1);
               end
            end else begin
               if (can_learn) begin
                  wr_en   = 1'b1;
                  wr_data = '{epoch: epoch_ff, key: look_key, code: next_ff[CODE_W-1:0]};
                  next_in = next_ff + NEXT_W'(1);
               end
               state_in = S_MISS;
            end
         end
         S_MISS: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_code_in  = prefix_ff;
               out_eos_in   = 1'b0;
               prefix_in    = CODE_W'(sym_ff);
               state_in     = last_ff ? S_FLUSH : S_IDLE;
            end
         end
         S_FLUSH: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_code_in  = prefix_ff;
               out_eos_in   = 1'b1;
               prefix_in    = '0;
               pvalid_in    = 1'b0;
               next_in      = NEXT_W'(ALPHABET_SIZE);
               if (epoch_ff == lzw_pkg::EPOCH_MAX) begin
                  epoch_in = lzw_pkg::EPOCH_FIRST;
                  addr_in  = '0;
                  state_in = S_CLEAR;
               end else begin
                  epoch_in = epoch_ff + EPOCH_W'(1);
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         pvalid_ff    <= 1'b0;
         prefix_ff    <= '0;
         next_ff      <= NEXT_W'(ALPHABET_SIZE);
         epoch_ff     <= lzw_pkg::EPOCH_FIRST;
         addr_ff      <= '0;
         limit_ff     <= '1;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pvalid_ff    <= pvalid_in;
         prefix_ff    <= prefix_in;
         next_ff      <= next_in;
         epoch_ff     <= epoch_in;
         addr_ff      <= addr_in;
         out_valid_ff <= out_valid_in;
         if (csr.valid) begin
            limit_ff <= csr.data;
         end
      end
      sym_ff      <= sym_in;
      last_ff     <= last_in;
      out_code_ff <= out_code_in;
      out_eos_ff  <= out_eos_in;
   end

   lzw_table #(
      .ADDR_W (TAB_W)
   ) u_table (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (addr_ff),
      .wr_data (wr_data)
   );

   assign req.ready         = (state_ff == S_IDLE);
   assign csr.ready         = 1'b1;
   assign rsp.valid         = out_valid_ff;
   assign rsp.code          = out_code_ff;
   assign rsp.end_of_stream = out_eos_ff;

`ifndef SYNTHESIS
   a_next_bounded: assert property (@(posedge clock) disable iff (reset)
      32'(next_ff) <= DICT_SIZE) else $error("next code ran past the table");

   a_flush_ends_stream: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FLUSH && out_free) |=> !pvalid_ff && next_ff == NEXT_W'(ALPHABET_SIZE))
      else $error("stream state not restarted after flush");

   a_write_states: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == S_CLEAR || state_ff == S_LOOK))
      else $error("table written outside clear or lookup");

   a_learn_epoch: assert property (@(posedge clock) disable iff (reset)
      (wr_en && state_ff == S_LOOK) |-> wr_data.epoch != lzw_pkg::EPOCH_NONE)
      else $error("learned entry carries the cleared epoch");

   a_no_read_write: assert property (@(posedge clock) disable iff (reset)
      !(rd_en && wr_en)) else $error("table read and written in one cycle");
`endif

endmodule

// ----- tb/lzw_encoder_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZW encoder testbench
// Drives symbol streams through the encoder under several code limits and
// random idling on both channels, and checks every code against a dictionary
// model kept here.
// ----------------------------------------------------------------------------
module lzw_encoder_tb;

   localparam int CODE_W  = lzw_pkg::CODE_W;
   localparam int SYM_W   = lzw_pkg::SYM_W;
   localparam int KEY_W   = lzw_pkg::KEY_W;
   localparam int N_DICT  = 4096;
   localparam int N_ALPHA = 128;
   localparam int LIMIT_CYCLES = 2000000;
   localparam logic [CODE_W-1:0] LIMIT_MAX = 12'd4095;

   typedef struct packed {
      logic [CODE_W-1:0] code;
      logic              eos;
   } code_word_type;

   typedef struct packed {
      logic [SYM_W-1:0]  symbol;
      logic              last;
      logic              has_exp;
      logic [CODE_W-1:0] exp_code;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   always #5 clock = ~clock;

   lzw_req_if req ();
   lzw_rsp_if rsp ();
   lzw_csr_if csr ();

   lzw_encoder i_dut (.clock(clock), .reset(reset), .req(req), .rsp(rsp), .csr(csr));

   // dictionary model
   logic [KEY_W-1:0]  dict_key [N_DICT];
   int unsigned       dict_next;
   logic [CODE_W-1:0] cur_prefix;
   logic              have_prefix;
   logic [CODE_W-1:0] limit_reg;

   code_word_type code_q[$];
   int  n_errors;
   int  send_idle_pct;
   int  recv_idle_pct;
   longint cycles;

   task automatic report(input string what);
      n_errors++;
      $display("ERROR %0t: %s", $realtime, what);
   endtask

   task automatic queue_code(input logic [CODE_W-1:0] c, input logic eos);
      code_word_type w;
      w.code = c;
      w.eos = eos;
      code_q.insert(code_q.size(), w);
   endtask

   task automatic encode_symbol(input logic [SYM_W-1:0] s, input logic last);
      int unsigned k;
      logic found;
      logic [CODE_W-1:0] hit;
      found = 1'b0;
      hit = '0;
      if (!have_prefix) begin
         cur_prefix = CODE_W'(s);
         have_prefix = 1'b1;
      end else begin
         for (k = N_ALPHA; k < dict_next && !found; k++) begin
            if (dict_key[k] == {cur_prefix, s}) begin
               found = 1'b1;
               hit = CODE_W'(k);
            end
         end
         if (found) begin
            cur_prefix = hit;
         end else begin
            queue_code(cur_prefix, 1'b0);
            if (dict_next <= limit_reg && dict_next < N_DICT) begin
               dict_key[dict_next] = {cur_prefix, s};
               dict_next++;
            end
            cur_prefix = CODE_W'(s);
         end
      end
      if (last) begin
         queue_code(cur_prefix, 1'b1);
         dict_next = N_ALPHA;
         cur_prefix = '0;
         have_prefix = 1'b0;
      end
   endtask

   // receiver: random stalls, check each accepted word
   always @(posedge clock) begin
      code_word_type want;
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (code_q.size() == 0) begin
               report($sformatf("unexpected code %0d", rsp.code));
            end else begin
               want = code_q.pop_front();
               if (rsp.code !== want.code)
                  report($sformatf("code %0d, want %0d", rsp.code, want.code));
               if (rsp.end_of_stream !== want.eos)
                  report($sformatf("end_of_stream %0b, want %0b",
                                   rsp.end_of_stream, want.eos));
            end
         end
         rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT_CYCLES) begin
         $display("lzw_encoder_tb: done, errors");
         $finish;
      end
   end

   // drop valid only on idle cycles, so back-to-back words keep it high
   task automatic send_word(input logic [SYM_W-1:0] s, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid <= 1'b1;
      req.symbol <= s;
      req.last_symbol <= last;
      encode_symbol(s, last);
      do @(posedge clock); while (!req.ready);
   endtask

   task automatic drain();
      req.valid <= 1'b0;
      while (code_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_limit(input logic [CODE_W-1:0] v);
      drain();
      csr.valid <= 1'b1;
      csr.data <= v;
      do @(posedge clock); while (!csr.ready);
      csr.valid <= 1'b0;
      limit_reg = v;
   endtask

   // one stream; repetitive alphabets make the dictionary hit often
   task automatic send_stream(input int len, input int alpha);
      int i;
      logic [SYM_W-1:0] s;
      for (i = 0; i < len; i++) begin
         s = (alpha >= N_ALPHA) ? SYM_W'($urandom) : SYM_W'($urandom_range(alpha - 1));
         send_word(s, i == len - 1);
      end
   endtask

   dir_row_type dir_rows [15] = '{
      '{7'd0,   1'b1, 1'b1, 12'd0},
      '{7'd127, 1'b1, 1'b1, 12'd127},
      '{7'd5,   1'b0, 1'b0, 12'd0},
      '{7'd5,   1'b0, 1'b0, 12'd0},
      '{7'd5,   1'b0, 1'b0, 12'd0},
      '{7'd5,   1'b0, 1'b0, 12'd0},
      '{7'd5,   1'b1, 1'b0, 12'd0},
      '{7'd1,   1'b0, 1'b0, 12'd0},
      '{7'd2,   1'b0, 1'b0, 12'd0},
      '{7'd1,   1'b0, 1'b0, 12'd0},
      '{7'd2,   1'b0, 1'b0, 12'd0},
      '{7'd1,   1'b0, 1'b0, 12'd0},
      '{7'd2,   1'b0, 1'b0, 12'd0},
      '{7'd127, 1'b0, 1'b0, 12'd0},
      '{7'd0,   1'b1, 1'b0, 12'd0}
   };

   initial begin
      int i, ph;
      req.valid <= 1'b0;
      req.symbol <= '0;
      req.last_symbol <= 1'b0;
      csr.valid <= 1'b0;
      csr.data <= '0;
      n_errors = 0;
      cycles = 0;
      send_idle_pct = 15;
      recv_idle_pct = 87;
      limit_reg = LIMIT_MAX;
      dict_next = N_ALPHA;
      have_prefix = 1'b0;
      cur_prefix = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[r]) begin
         if (dir_rows[r].has_exp) begin
            // single-symbol stream: flush is the symbol's own code
            send_word(dir_rows[r].symbol, dir_rows[r].last);
            if (code_q[$].code !== dir_rows[r].exp_code)
               report("directed row prediction disagrees");
         end else begin
            send_word(dir_rows[r].symbol, dir_rows[r].last);
         end
      end

      // limit below the alphabet: nothing learned
      write_limit(12'd0);
      send_stream(12, 2);
      write_limit(12'd255);
      send_stream(300, 128);
      send_stream(200, 3);
      write_limit(LIMIT_MAX);

      for (ph = 0; ph < 3; ph++) begin
         if (ph == 1) begin send_idle_pct = 87; recv_idle_pct = 15; end
         if (ph == 2) begin send_idle_pct = 0;  recv_idle_pct = 0;  end
         write_limit(ph == 0 ? 12'd300 : (ph == 1 ? 12'd129 : LIMIT_MAX));
         for (i = 0; i < 40; i++) begin
            send_stream($urandom_range(1, 8), $urandom_range(0, 3) == 0 ? 128
                                             : $urandom_range(1, 6));
            if (i == 20) drain();
         end
      end
      // one long stream of random symbols
      send_stream(500, 128);

      drain();
      if (n_errors == 0) begin
         $display("lzw_encoder_tb: done, clean");
      end else begin
         $display("lzw_encoder_tb: done, errors");
      end
      $finish;
   end

endmodule

// ----- files.f -----
sv/lzw_pkg.sv
sv/lzw_if.sv
sv/lzw_table.sv
sv/lzw_encoder.sv
tb/lzw_encoder_tb.sv
